// ----- hw/rtl/dual_mode_pid_step_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual-mode PID step unit
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_PID_STEP_UNIT_MACROS_SVH
`define DUAL_MODE_PID_STEP_UNIT_MACROS_SVH

// Same-cycle implication
`define DMPID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmpid assertion failed");

// Next-cycle implication
`define DMPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmpid assertion failed");

`endif

// ----- hw/rtl/dmpid_pkg.sv -----
// ----------------------------------------------------------------------------
// dmpid_pkg
// Widths, register map, configuration and pipeline stage types.
// ----------------------------------------------------------------------------
package dmpid_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int IN_W           = 16;
  localparam int ERR_W          = IN_W + 1;
  localparam int HIST_W         = ERR_W + 1;
  localparam int OPND_W         = HIST_W + 2;
  localparam int GAIN_W         = 24;
  localparam int PROD_W         = GAIN_W + OPND_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int DRIVE_W        = 32;
  localparam int LIMIT_W        = 16;
  localparam int APB_AW         = 5;
  localparam int APB_DW         = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

  typedef enum logic [2:0] {
    REG_LOOP_MODE   = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_AVG_LIMIT   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    MODE_INCREMENTAL = 1'b0,
    MODE_POSITIONAL  = 1'b1
  } loop_mode_t;

  typedef struct packed {
    loop_mode_t                 loop_mode;
    logic signed [GAIN_W-1:0]   prop_gain;
    logic signed [GAIN_W-1:0]   integ_gain;
    logic signed [GAIN_W-1:0]   deriv_gain;
    logic        [LIMIT_W-1:0]  average_limit;
  } cfg_t;

  // Multiplier operands, one per gain
  typedef struct packed {
    loop_mode_t                 mode;
    logic signed [OPND_W-1:0]   op_p;
    logic signed [OPND_W-1:0]   op_i;
    logic signed [OPND_W-1:0]   op_d;
  } opnd_stage_t;

  typedef struct packed {
    loop_mode_t                 mode;
    logic signed [PROD_W-1:0]   prod_p;
    logic signed [PROD_W-1:0]   prod_i;
    logic signed [PROD_W-1:0]   prod_d;
  } prod_stage_t;

endpackage

// ----- hw/rtl/dmpid_cfg.sv -----
// ----------------------------------------------------------------------------
// dmpid_cfg
// APB register file holding mode, gains and the averaging clamp.
// ----------------------------------------------------------------------------
module dmpid_cfg
  import dmpid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode     <= MODE_INCREMENTAL;
      cfg.prop_gain     <= '0;
      cfg.integ_gain    <= '0;
      cfg.deriv_gain    <= '0;
      cfg.average_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOOP_MODE:  cfg.loop_mode     <= loop_mode_t'(pwdata[0]);
        REG_PROP_GAIN:  cfg.prop_gain     <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain    <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain    <= pwdata[GAIN_W-1:0];
        REG_AVG_LIMIT:  cfg.average_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOOP_MODE:  prdata = {{(APB_DW-1){1'b0}}, cfg.loop_mode};
      REG_PROP_GAIN:  prdata = APB_DW'(cfg.prop_gain);
      REG_INTEG_GAIN: prdata = APB_DW'(cfg.integ_gain);
      REG_DERIV_GAIN: prdata = APB_DW'(cfg.deriv_gain);
      REG_AVG_LIMIT:  prdata = {{(APB_DW-LIMIT_W){1'b0}}, cfg.average_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/dual_mode_pid_step_unit.sv -----
// ----------------------------------------------------------------------------
// dual_mode_pid_step_unit
// Incremental / positional PID step with saturated 32-bit drive.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless back-pressure from m_tready stalls
// the pipeline, and returns one drive per transaction. The drive passes
// through the operand, product and result registers in turn. The rate is set
// by the error history update, which completes in the accepting cycle so the
// next transaction sees it at once. Setting the clear flag in s_tuser empties
// the history and returns a zero drive. Registers: loop_mode at 0x00,
// prop_gain 0x04, integ_gain 0x08, deriv_gain 0x0C (signed Q8.16),
// average_limit 0x10. Write registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "dual_mode_pid_step_unit_macros.svh"

module dual_mode_pid_step_unit
  import dmpid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic              s_tuser,   // [0] clear
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [31:0] drive
  output logic              m_tuser    // [0] drive_saturated
);

  cfg_t cfg;

  dmpid_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Error history
  logic signed [ERR_W-1:0]  prev_error,  prev_error_next;
  logic signed [HIST_W-1:0] hist,        hist_next;

  logic        s1_valid, s2_valid;
  logic        s2_ready, s3_ready;
  logic        accept;
  opnd_stage_t s1, s1_next;
  prod_stage_t s2;

  logic signed [IN_W-1:0]   setpoint, measured;
  logic signed [ERR_W-1:0]  err;
  logic signed [OPND_W-1:0] e_x, e1_x, e2_x;
  logic signed [HIST_W:0]   half_raw, half_clamp, lim2;

  logic signed [SUM_W-1:0]  sum, shifted;
  logic                     in_range;
  logic [DRIVE_W-1:0]       drive_next;

  assign s3_ready = !m_tvalid || m_tready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s_tready = !s1_valid || s2_ready;
  assign accept   = s_tvalid && s_tready;

  assign setpoint = s_tdata[IN_W-1:0];
  assign measured = s_tdata[2*IN_W-1:IN_W];

  // Operand formation and history update
  always_comb begin
    err        = ERR_W'(setpoint) - ERR_W'(measured);
    e_x        = OPND_W'(err);
    e1_x       = OPND_W'(prev_error);
    e2_x       = OPND_W'(hist);
    lim2       = $signed({2'b00, cfg.average_limit, 1'b0});
    half_raw   = (HIST_W+1)'(err) + (HIST_W+1)'(hist >>> 1);
    if (half_raw > lim2) begin
      half_clamp = lim2;
    end else if (half_raw < -lim2) begin
      half_clamp = -lim2;
    end else begin
      half_clamp = half_raw;
    end

    s1_next.mode = cfg.loop_mode;
    if (s_tuser) begin
      s1_next.op_p    = '0;
      s1_next.op_i    = '0;
      s1_next.op_d    = '0;
      prev_error_next = '0;
      hist_next       = '0;
    end else if (cfg.loop_mode == MODE_INCREMENTAL) begin
      s1_next.op_p    = e_x - e1_x;
      s1_next.op_i    = e_x;
      s1_next.op_d    = e_x - (e1_x <<< 1) + e2_x;
      prev_error_next = err;
      hist_next       = HIST_W'(prev_error);
    end else begin
      // Operands doubled so that the average keeps its half bit
      s1_next.op_p    = e_x <<< 1;
      s1_next.op_i    = OPND_W'(half_clamp);
      s1_next.op_d    = (e_x - e1_x) <<< 1;
      prev_error_next = err;
      hist_next       = HIST_W'(half_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      hist       <= '0;
    end else if (accept) begin
      prev_error <= prev_error_next;
      hist       <= hist_next;
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2.mode   <= s1.mode;
      s2.prod_p <= s1.op_p * cfg.prop_gain;
      s2.prod_i <= s1.op_i * cfg.integ_gain;
      s2.prod_d <= s1.op_d * cfg.deriv_gain;
    end
  end

  // Sum, floor shift and saturate
  always_comb begin
    sum = SUM_W'(s2.prod_p) + SUM_W'(s2.prod_i) + SUM_W'(s2.prod_d);
    if (s2.mode == MODE_POSITIONAL) begin
      shifted = sum >>> (GAIN_FRAC_BITS + 1);
    end else begin
      shifted = sum >>> GAIN_FRAC_BITS;
    end
    in_range = (&shifted[SUM_W-1:DRIVE_W-1]) || !(|shifted[SUM_W-1:DRIVE_W-1]);
    if (in_range) begin
      drive_next = shifted[DRIVE_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s3_ready) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      m_tdata <= drive_next;
      m_tuser <= !in_range;
    end
  end

  `DMPID_ASSERT_NEXT(a_clear_empties, accept && s_tuser, prev_error == '0 && hist == '0)
  `DMPID_ASSERT_NEXT(a_avg_bounded,
    accept && !s_tuser && cfg.loop_mode == MODE_POSITIONAL,
    (HIST_W+1)'(hist) <= lim2 && (HIST_W+1)'(hist) >= -lim2)
  `DMPID_ASSERT_NEXT(a_stage_moves, s1_valid && s2_ready, s2_valid)
  `DMPID_ASSERT_SAME(a_sat_value, m_tvalid && m_tuser,
    m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)

endmodule

// ----- verif/dual_mode_pid_step_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_pid_step_checker
// Watches the register port and both streams, predicts every drive from its
// own copy of the gains and error history, and compares in order.
// ----------------------------------------------------------------------------
module dual_mode_pid_step_checker
  import dmpid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [31:0]       s_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic              s_tuser,   // [0] clear
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,   // [31:0] drive
  input  logic              m_tuser,   // [0] drive_saturated
  output int                mismatches,
  output int                drives_seen,
  output int                drives_owed
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } drive_t;

  cfg_t                     cfg;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [HIST_W-1:0] hist;       // e2 when incremental, average in halves when positional
  drive_t                   owed_q[$];
  int                       n_bad;
  int                       n_seen;

  function automatic drive_t pid_drive(logic signed [IN_W-1:0] sp,
                                       logic signed [IN_W-1:0] meas, logic clr);
    longint e, e1, acc, half, lim2, kp, ki, kd;
    drive_t r;
    r.drive     = '0;
    r.saturated = 1'b0;
    if (clr) begin
      last_err = '0;
      hist     = '0;
      return r;
    end
    kp = longint'(signed'(cfg.prop_gain));
    ki = longint'(signed'(cfg.integ_gain));
    kd = longint'(signed'(cfg.deriv_gain));
    e  = longint'(sp) - longint'(meas);
    e1 = longint'(last_err);
    if (cfg.loop_mode == MODE_INCREMENTAL) begin
      acc  = kp * (e - e1) + ki * e + kd * (e - 2 * e1 + longint'(hist));
      acc  = acc >>> GAIN_FRAC_BITS;
      hist = HIST_W'(e1);
    end else begin
      // average kept in halves: new = e + floor(old / 2), then clamp
      half = e + (longint'(hist) >>> 1);
      lim2 = 2 * longint'(cfg.average_limit);
      if (half > lim2) half = lim2;
      else if (half < -lim2) half = -lim2;
      hist = HIST_W'(half);
      acc  = 2 * kp * e + ki * half + 2 * kd * (e - e1);
      acc  = acc >>> (GAIN_FRAC_BITS + 1);
    end
    last_err = ERR_W'(e);
    if (acc > 64'sd2147483647) begin
      r.drive     = 32'sh7FFF_FFFF;
      r.saturated = 1'b1;
    end else if (acc < -64'sd2147483648) begin
      r.drive     = 32'sh8000_0000;
      r.saturated = 1'b1;
    end else begin
      r.drive = acc[DRIVE_W-1:0];
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, drive_t want);
    n_bad++;
    if (n_bad <= 10) begin
      $display("[%0t] %s: expected drive %0d sat %0b, got drive %0d sat %0b",
               $realtime, what, want.drive, want.saturated, $signed(m_tdata), m_tuser);
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      cfg.loop_mode     = MODE_INCREMENTAL;
      cfg.prop_gain     = '0;
      cfg.integ_gain    = '0;
      cfg.deriv_gain    = '0;
      cfg.average_limit = LIMIT_RESET;
      last_err          = '0;
      hist              = '0;
      owed_q.delete();
      n_bad             = 0;
      n_seen            = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_LOOP_MODE:  cfg.loop_mode     = loop_mode_t'(pwdata[0]);
          REG_PROP_GAIN:  cfg.prop_gain     = pwdata[GAIN_W-1:0];
          REG_INTEG_GAIN: cfg.integ_gain    = pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN: cfg.deriv_gain    = pwdata[GAIN_W-1:0];
          REG_AVG_LIMIT:  cfg.average_limit = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // take the result before the new transaction so nothing is matched early
      if (m_tvalid && m_tready) begin
        n_seen++;
        if (owed_q.size() == 0) begin
          want = '0;
          note_mismatch("drive with nothing owed", want);
        end else begin
          want = owed_q.pop_front();
          if (m_tdata !== want.drive || m_tuser !== want.saturated)
            note_mismatch("drive mismatch", want);
        end
      end
      if (s_tvalid && s_tready)
        owed_q.push_back(pid_drive(s_tdata[15:0], s_tdata[31:16], s_tuser));
    end
    mismatches  <= n_bad;
    drives_seen <= n_seen;
    drives_owed <= owed_q.size();
  end

endmodule

// ----- verif/dual_mode_pid_step_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mode_pid_step_unit_tb
// Drives register settings and setpoint/measurement transactions into the
// PID step unit with random gaps and back-pressure; the checker predicts and
// compares every drive.
// ----------------------------------------------------------------------------
module dual_mode_pid_step_unit_tb;
  import dmpid_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE          = 8;    // pipeline is three deep
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int REG_SLOTS       = 8;    // indexes reachable through paddr[4:2]

  localparam logic [IN_W-1:0] LEVEL_TOP    = 16'h7FFF;
  localparam logic [IN_W-1:0] LEVEL_BOTTOM = 16'h8000;
  localparam logic [31:0]     GAIN_MAX     = 32'h007F_FFFF;
  localparam logic [31:0]     GAIN_MIN     = 32'h0080_0000;

  logic              clk;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [APB_DW-1:0] pwdata   = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic              m_tuser;

  int mismatches;
  int drives_seen;
  int drives_owed;
  int sent       = 0;
  int clears     = 0;
  int reg_writes = 0;
  int cycles     = 0;
  int idle_pct   = 0;
  int stall_left = 0;

  dual_mode_pid_step_unit u_dut (.*);

  dual_mode_pid_step_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_tready <= (stall_left == 0);
    end
  end

  // setup, access, then idle before the next transfer
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // hold valid until the transaction goes through, then maybe pause
  task automatic send_item(logic [IN_W-1:0] sp, logic [IN_W-1:0] meas, logic clr);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {meas, sp};
    s_tuser  <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (clr) clears++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= $urandom_range(1);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (drives_seen != sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_level();
    int r;
    r = $urandom_range(9);
    if (r == 0) return LEVEL_TOP;
    if (r == 1) return LEVEL_BOTTOM;
    if (r < 5) return IN_W'($urandom_range(255)) - IN_W'(128);
    return IN_W'($urandom);
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] w;
    int r;
    w = $urandom;
    r = $urandom_range(9);
    if (r == 0) w[GAIN_W-1:0] = GAIN_MAX[GAIN_W-1:0];
    else if (r == 1) w[GAIN_W-1:0] = GAIN_MIN[GAIN_W-1:0];
    else if (r < 5) w[GAIN_W-1:0] = GAIN_W'($urandom_range(262143)) - GAIN_W'(131072);
    return w;
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] w;
    int r;
    w = $urandom;
    r = $urandom_range(9);
    if (r == 0) w[LIMIT_W-1:0] = '0;
    else if (r == 1) w[LIMIT_W-1:0] = '1;
    else if (r < 5) w[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 300));
    return w;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero gains give zero drive while the history builds
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(16'd5, 16'd9, 1'b0);
    drain();

    reg_write(REG_LOOP_MODE, 32'(MODE_INCREMENTAL));
    reg_write(REG_PROP_GAIN, GAIN_MAX);
    reg_write(REG_INTEG_GAIN, GAIN_MIN);
    reg_write(REG_DERIV_GAIN, GAIN_MAX);
    // full-scale error swings, then a clear in the middle of them
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_BOTTOM, LEVEL_TOP, 1'b0);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b1);
    send_item(LEVEL_BOTTOM, LEVEL_TOP, 1'b0);
    send_item(16'h0100, 16'h0103, 1'b0);
    drain();

    // unmapped slots must not disturb any register
    for (int k = int'(REG_AVG_LIMIT) + 1; k < REG_SLOTS; k++)
      reg_write(3'(k), $urandom);
    reg_write(REG_LOOP_MODE, 32'(MODE_POSITIONAL));
    reg_write(REG_DERIV_GAIN, GAIN_MIN);
    reg_write(REG_AVG_LIMIT, 32'd0);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_BOTTOM, LEVEL_TOP, 1'b0);
    send_item(16'd1, 16'd0, 1'b0);
    drain();

    // tight clamp both ways and odd negative errors for the rounding
    reg_write(REG_AVG_LIMIT, 32'd100);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_BOTTOM, LEVEL_TOP, 1'b0);
    send_item(16'd0, 16'd3, 1'b0);
    send_item(16'd0, 16'd3, 1'b0);
    drain();

    reg_write(REG_AVG_LIMIT, 32'h0000_FFFF);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_TOP, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_BOTTOM, LEVEL_TOP, 1'b0);
    drain();

    // switch mode with the average still held: it is read as e2
    reg_write(REG_LOOP_MODE, 32'(MODE_INCREMENTAL));
    send_item(16'd7, LEVEL_BOTTOM, 1'b0);
    send_item(LEVEL_TOP, 16'd7, 1'b0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 25;
        default: idle_pct = 65;
      endcase
      reg_write(REG_LOOP_MODE, $urandom);
      reg_write(REG_PROP_GAIN, pick_gain());
      reg_write(REG_INTEG_GAIN, pick_gain());
      reg_write(REG_DERIV_GAIN, pick_gain());
      reg_write(REG_AVG_LIMIT, pick_limit());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off now and then until every drive is back
        if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 1) drain();
        send_item(pick_level(), pick_level(), $urandom_range(99) < 3);
      end
      drain();
    end

    $display("Sent %0d transactions (%0d clears) across %0d register writes, both loop modes",
             sent, clears, reg_writes);
    $display("Checked %0d drives including full-scale errors and averaging clamps",
             drives_seen);
    if (mismatches == 0 && drives_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
